// ===== hw/rtl/pti_pkg.sv =====
// ----------------------------------------------------------------------------
// pti_pkg
// Types and codes shared by the pose table interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

  localparam int unsigned TableDepthDef = 1024;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] STAT_INTERP  = 3'd0;
  localparam logic [2:0] STAT_FIRST   = 3'd1;
  localparam logic [2:0] STAT_LAST    = 3'd2;
  localparam logic [2:0] STAT_EMPTY   = 3'd3;
  localparam logic [2:0] STAT_LOADED  = 3'd4;
  localparam logic [2:0] STAT_FULL    = 3'd5;
  localparam logic [2:0] STAT_CLEARED = 3'd6;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        time_us;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } pti_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_qx;
    logic signed [15:0] out_qy;
    logic signed [15:0] out_qz;
    logic signed [15:0] out_qw;
    logic [2:0]         status;
  } pti_out_t;

  // Table entry: relative time, position x/y/z, quaternion x/y/z/w.
  typedef struct packed {
    logic [31:0]       t;
    logic [2:0][31:0]  pos;
    logic [3:0][15:0]  quat;
  } pti_entry_t;

endpackage

// ===== hw/rtl/pose_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// pose_table_interpolator
// Timestamped pose table with clamped lookup and interpolated, normalized pose.
// ----------------------------------------------------------------------------
// Pulse start_i with an item while busy_o is low. Load, clear and queries on
// an empty table give their result on done_o in the next cycle and leave the
// block free at once. A clamped query makes one table read. An interpolating
// query runs a sequencer over one table read port and one shared multiplier
// and divider: a binary search of the table, the last probe, the two neighbor
// reads, a divider run for the blend weight, multiplies for the seven blends,
// the squared norm, square-root steps and a normalizing division per
// quaternion component, then the output.
// Results are shown for one cycle on done_o and cannot be held off.
module pose_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = pti_pkg::TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pti_pkg::pti_in_t  req_i,
  output logic              busy_o,
  output logic              done_o,
  output pti_pkg::pti_out_t rsp_o
);
  import pti_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLAMP = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_RDB   = 4'd5;
  localparam logic [3:0] S_DIVA  = 4'd6;
  localparam logic [3:0] S_LERP  = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_SQCHK = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_NSET  = 4'd11;
  localparam logic [3:0] S_DIVN  = 4'd12;
  localparam logic [3:0] S_NFIN  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // control
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   base_q, base_d;
  logic [31:0]   last_q, last_d;
  logic          done_q, done_d;

  // datapath
  logic [31:0]      t_q, t_d;
  logic [AW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  pti_entry_t       a_q, a_d, b_q, b_d;
  logic [2:0]       stat_q, stat_d;
  logic [2:0]       comp_q, comp_d;
  logic [1:0]       ph_q, ph_d;
  logic [63:0]      acc_q, acc_d;
  logic [2:0][31:0] pos_q, pos_d;
  logic [3:0][15:0] quat_q, quat_d;
  logic [32:0]      s_q, s_d;
  logic [63:0]      x_q, x_d, root_q, root_d, bit_q, bit_d;
  logic [31:0]      div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [29:0]      div_num_q, div_num_d, div_quot_q, div_quot_d;
  logic [4:0]       div_cnt_q, div_cnt_d;
  pti_out_t         res_q, res_d;

  // table memory
  pti_entry_t    mem [TABLE_DEPTH];
  pti_entry_t    rd_q, wdata;
  logic          we;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  // shared arithmetic
  logic [2:0]         qidx;
  logic signed [33:0] av, bv, dif, lerp_v;
  logic [32:0]        mag;
  logic               neg;
  logic signed [16:0] qs;
  logic [16:0]        qmag;
  logic [16:0]        mul_a;
  logic [29:0]        mul_b;
  logic [46:0]        prod;
  logic [63:0]        rnd;
  logic [32:0]        div_tmp;
  logic               div_ge;
  logic [31:0]        div_nrem;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [45:0]        nnum;
  logic [15:0]        nsat;
  logic [AW-1:0]      span, mid, cntm1;
  logic [31:0]        rel;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = res_q;
  assign waddr  = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_comb begin
    qidx = comp_q - 3'd3;
    if (comp_q < 3'd3) begin
      av = {{2{a_q.pos[comp_q[1:0]][31]}}, a_q.pos[comp_q[1:0]]};
      bv = {{2{b_q.pos[comp_q[1:0]][31]}}, b_q.pos[comp_q[1:0]]};
    end else begin
      av = {{18{a_q.quat[qidx[1:0]][15]}}, a_q.quat[qidx[1:0]]};
      bv = {{18{b_q.quat[qidx[1:0]][15]}}, b_q.quat[qidx[1:0]]};
    end
    dif = bv - av;
    neg = dif[33];
    mag = neg ? 33'(-dif) : 33'(dif);

    qs   = {quat_q[comp_q[1:0]][15], quat_q[comp_q[1:0]]};
    qmag = qs[16] ? 17'(-qs) : 17'(qs);

    mul_a = '0;
    mul_b = '0;
    if (state_q == S_LERP) begin
      mul_a = (ph_q == 2'd0) ? mag[16:0] : {1'b0, mag[32:17]};
      mul_b = div_quot_q;
    end else if (state_q == S_SQ) begin
      mul_a = qmag;
      mul_b = {13'd0, qmag};
    end
    prod = 47'(mul_a) * 47'(mul_b);

    // round half up, then step from the earlier sample toward the later one
    rnd    = acc_q + 64'(1 << 29);
    lerp_v = neg ? (av - $signed({1'b0, rnd[62:30]})) : (av + $signed({1'b0, rnd[62:30]}));

    div_tmp  = {div_rem_q, div_num_q[29]};
    div_ge   = (div_tmp >= {1'b0, div_den_q});
    div_nrem = div_ge ? 32'(div_tmp - {1'b0, div_den_q}) : div_tmp[31:0];

    trial = root_q + bit_q;
    sq_ge = (x_q >= trial);

    nnum = {qmag, 29'd0} + {14'd0, root_q[31:0]};
    nsat = (div_quot_q[15:0] > 16'd16384) ? 16'd16384 : div_quot_q[15:0];

    span  = hi_q - lo_q;
    mid   = lo_q + (span >> 1);
    cntm1 = AW'(cnt_q - 1'b1);
    rel   = req_i.time_us - base_q;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    last_d     = last_q;
    done_d     = 1'b0;
    t_d        = t_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    a_d        = a_q;
    b_d        = b_q;
    stat_d     = stat_q;
    comp_d     = comp_q;
    ph_d       = ph_q;
    acc_d      = acc_q;
    pos_d      = pos_q;
    quat_d     = quat_q;
    s_d        = s_q;
    x_d        = x_q;
    root_d     = root_q;
    bit_d      = bit_q;
    div_rem_d  = div_rem_q;
    div_den_d  = div_den_q;
    div_num_d  = div_num_q;
    div_quot_d = div_quot_q;
    div_cnt_d  = div_cnt_q;
    res_d      = res_q;
    we         = 1'b0;
    wdata      = '0;
    raddr      = '0;

    if (state_q == S_DIVA || state_q == S_DIVN) begin
      div_rem_d  = div_nrem;
      div_quot_d = {div_quot_q[28:0], div_ge};
      div_num_d  = {div_num_q[28:0], 1'b0};
      div_cnt_d  = div_cnt_q - 5'd1;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          t_d = req_i.time_us;
          case (req_i.action)
            ACT_LOAD: begin
              res_d  = '0;
              done_d = 1'b1;
              if (cnt_q >= CW'(TABLE_DEPTH)) begin
                res_d.status = STAT_FULL;
              end else begin
                res_d.status = STAT_LOADED;
                wdata.pos    = {req_i.pos_z, req_i.pos_y, req_i.pos_x};
                wdata.quat   = {req_i.quat_w, req_i.quat_z, req_i.quat_y, req_i.quat_x};
                if (cnt_q == '0) begin
                  base_d  = req_i.time_us;
                  wdata.t = '0;
                end else if (rel < last_q) begin
                  wdata.t = last_q;
                end else begin
                  wdata.t = rel;
                end
                we     = 1'b1;
                last_d = wdata.t;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            ACT_CLEAR: begin
              cnt_d        = '0;
              base_d       = '0;
              res_d        = '0;
              res_d.status = STAT_CLEARED;
              done_d       = 1'b1;
            end
            ACT_QUERY: begin
              if (cnt_q == '0) begin
                res_d        = '0;
                res_d.status = STAT_EMPTY;
                done_d       = 1'b1;
              end else if (req_i.time_us == '0) begin
                raddr   = '0;
                stat_d  = STAT_FIRST;
                state_d = S_CLAMP;
              end else if (req_i.time_us >= last_q) begin
                raddr   = cntm1;
                stat_d  = STAT_LAST;
                state_d = S_CLAMP;
              end else begin
                lo_d    = '0;
                hi_d    = cntm1;
                state_d = S_SRCH;
              end
            end
            default: begin
              // drop unknown action
            end
          endcase
        end
      end
      S_CLAMP: begin
        res_d.out_x  = rd_q.pos[0];
        res_d.out_y  = rd_q.pos[1];
        res_d.out_z  = rd_q.pos[2];
        res_d.out_qx = rd_q.quat[0];
        res_d.out_qy = rd_q.quat[1];
        res_d.out_qz = rd_q.quat[2];
        res_d.out_qw = rd_q.quat[3];
        res_d.status = stat_q;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      S_SRCH: begin
        if (span > AW'(1)) begin
          raddr   = mid;
          mid_d   = mid;
          state_d = S_SCMP;
        end else begin
          raddr   = lo_q;
          state_d = S_RDA;
        end
      end
      S_SCMP: begin
        if (rd_q.t <= t_q) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end
      S_RDA: begin
        a_d     = rd_q;
        raddr   = hi_q;
        state_d = S_RDB;
      end
      S_RDB: begin
        b_d        = rd_q;
        div_rem_d  = t_q - a_q.t;
        div_den_d  = rd_q.t - a_q.t;
        div_num_d  = '0;
        div_quot_d = '0;
        div_cnt_d  = 5'd30;
        state_d    = S_DIVA;
      end
      S_DIVA: begin
        if (div_cnt_q == 5'd1) begin
          comp_d  = '0;
          ph_d    = '0;
          state_d = S_LERP;
        end
      end
      S_LERP: begin
        case (ph_q)
          2'd0: begin
            acc_d = 64'(prod);
            ph_d  = 2'd1;
          end
          2'd1: begin
            acc_d = acc_q + (64'(prod) << 17);
            ph_d  = 2'd2;
          end
          default: begin
            if (comp_q < 3'd3) begin
              pos_d[comp_q[1:0]] = lerp_v[31:0];
            end else begin
              quat_d[qidx[1:0]] = lerp_v[15:0];
            end
            ph_d = 2'd0;
            if (comp_q == 3'd6) begin
              comp_d  = '0;
              s_d     = '0;
              state_d = S_SQ;
            end else begin
              comp_d = comp_q + 3'd1;
            end
          end
        endcase
      end
      S_SQ: begin
        s_d = s_q + 33'(prod);
        if (comp_q == 3'd3) begin
          state_d = S_SQCHK;
        end else begin
          comp_d = comp_q + 3'd1;
        end
      end
      S_SQCHK: begin
        if (s_q == '0) begin
          state_d = S_OUT;
        end else begin
          x_d     = {3'd0, s_q, 28'd0};
          root_d  = '0;
          bit_d   = 64'd1 << 62;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          x_d    = x_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          comp_d  = '0;
          state_d = S_NSET;
        end
      end
      S_NSET: begin
        div_rem_d  = {2'd0, nnum[45:16]};
        div_num_d  = {nnum[15:0], 14'd0};
        div_den_d  = {root_q[30:0], 1'b0};
        div_quot_d = '0;
        div_cnt_d  = 5'd16;
        state_d    = S_DIVN;
      end
      S_DIVN: begin
        if (div_cnt_q == 5'd1) begin
          state_d = S_NFIN;
        end
      end
      S_NFIN: begin
        quat_d[comp_q[1:0]] = qs[16] ? 16'(-nsat) : nsat;
        if (comp_q == 3'd3) begin
          state_d = S_OUT;
        end else begin
          comp_d  = comp_q + 3'd1;
          state_d = S_NSET;
        end
      end
      S_OUT: begin
        res_d.out_x  = pos_q[0];
        res_d.out_y  = pos_q[1];
        res_d.out_z  = pos_q[2];
        res_d.out_qx = quat_q[0];
        res_d.out_qy = quat_q[1];
        res_d.out_qz = quat_q[2];
        res_d.out_qw = quat_q[3];
        res_d.status = STAT_INTERP;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      base_q  <= '0;
      last_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      last_q  <= last_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    a_q        <= a_d;
    b_q        <= b_d;
    stat_q     <= stat_d;
    comp_q     <= comp_d;
    ph_q       <= ph_d;
    acc_q      <= acc_d;
    pos_q      <= pos_d;
    quat_q     <= quat_d;
    s_q        <= s_d;
    x_q        <= x_d;
    root_q     <= root_d;
    bit_q      <= bit_d;
    div_rem_q  <= div_rem_d;
    div_den_q  <= div_den_d;
    div_num_q  <= div_num_d;
    div_quot_q <= div_quot_d;
    div_cnt_q  <= div_cnt_d;
    res_q      <= res_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_pose_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == STAT_INTERP || rsp_o.status == STAT_FIRST ||
               rsp_o.status == STAT_LAST) |-> $past(busy_o))
    else $error("pose result without a table access");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> $onehot(bit_q))
    else $error("square root trial bit lost");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.action == ACT_CLEAR |=> cnt_q == '0)
    else $error("clear left entries");

endmodule

// ===== dv/pose_table_interpolator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_table_interpolator_test
// Self-checking bench: a directed table of loads, clears and queries, then
// random load/query sequences and one full-table fill, with every result
// compared against a typed expectation or an in-bench pose predictor.
// ----------------------------------------------------------------------------
module pose_table_interpolator_test;
  import pti_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned StallLimit = 5000;
  localparam logic [1:0]  ActUnused = 2'd3;

  typedef struct {
    pti_in_t  req;
    bit       typed;
    pti_out_t rsp;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  pti_in_t  req_i = '0;
  logic     busy_o;
  logic     done_o;
  pti_out_t rsp_o;

  pose_table_interpolator uut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [31:0] pt_time [Depth];
  int          pt_pos  [Depth][3];
  int          pt_quat [Depth][4];
  int unsigned pt_count = 0;
  logic [31:0] pt_base = '0;

  pti_out_t  pose_q[$];
  bit        typed_q[$];
  pti_out_t  typed_rsp_q[$];
  bit        failed = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct;

  function automatic int blend(int a, int b, longint unsigned w);
    longint d;
    longint unsigned m;
    longint unsigned r;
    d = longint'(b) - longint'(a);
    m = (d < 0) ? longint'(-d) : longint'(d);
    r = (m * w + (64'd1 << 29)) >> 30;
    return (d < 0) ? int'(longint'(a) - longint'(r)) : int'(longint'(a) + longint'(r));
  endfunction

  function automatic longint unsigned root(longint unsigned x);
    longint unsigned res;
    longint unsigned trial;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= x) res = trial;
    end
    return res;
  endfunction

  function automatic pti_out_t pose_rsp(int p[3], int q[4], logic [2:0] st);
    pti_out_t r;
    r.out_x = p[0]; r.out_y = p[1]; r.out_z = p[2];
    r.out_qx = q[0][15:0]; r.out_qy = q[1][15:0];
    r.out_qz = q[2][15:0]; r.out_qw = q[3][15:0];
    r.status = st;
    return r;
  endfunction

  // Advance the predictor by one accepted item; returns 1 if it yields a result.
  function automatic bit predict_pose(pti_in_t it, output pti_out_t r);
    int zp[3] = '{0, 0, 0};
    int zq[4] = '{0, 0, 0, 0};
    int p[3];
    int q[4];
    int unsigned lo, hi, mid;
    logic [31:0] rel;
    longint unsigned dt, w, s, n, m, v;
    case (it.action)
      ACT_LOAD: begin
        if (pt_count >= Depth) begin
          r = pose_rsp(zp, zq, STAT_FULL);
          return 1;
        end
        if (pt_count == 0) pt_base = it.time_us;
        rel = it.time_us - pt_base;
        if (pt_count > 0 && rel < pt_time[pt_count-1]) rel = pt_time[pt_count-1];
        pt_time[pt_count] = rel;
        pt_pos[pt_count] = '{it.pos_x, it.pos_y, it.pos_z};
        pt_quat[pt_count] = '{int'(it.quat_x), int'(it.quat_y),
                              int'(it.quat_z), int'(it.quat_w)};
        pt_count++;
        r = pose_rsp(zp, zq, STAT_LOADED);
        return 1;
      end
      ACT_CLEAR: begin
        pt_count = 0;
        pt_base = '0;
        r = pose_rsp(zp, zq, STAT_CLEARED);
        return 1;
      end
      ACT_QUERY: begin
        if (pt_count == 0) begin
          r = pose_rsp(zp, zq, STAT_EMPTY);
          return 1;
        end
        if (it.time_us <= pt_time[0]) begin
          r = pose_rsp(pt_pos[0], pt_quat[0], STAT_FIRST);
          return 1;
        end
        if (it.time_us >= pt_time[pt_count-1]) begin
          r = pose_rsp(pt_pos[pt_count-1], pt_quat[pt_count-1], STAT_LAST);
          return 1;
        end
        lo = 0;
        hi = pt_count - 1;
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          if (pt_time[mid] <= it.time_us) lo = mid;
          else hi = mid;
        end
        dt = longint'(pt_time[hi]) - longint'(pt_time[lo]);
        if (dt == 0) dt = 1;
        w = (longint'(it.time_us - pt_time[lo]) << 30) / dt;
        s = 0;
        for (int i = 0; i < 3; i++) p[i] = blend(pt_pos[lo][i], pt_pos[hi][i], w);
        for (int i = 0; i < 4; i++) begin
          q[i] = blend(pt_quat[lo][i], pt_quat[hi][i], w);
          s += longint'(q[i]) * longint'(q[i]);
        end
        if (s != 0) begin
          n = root(s << 28);
          for (int i = 0; i < 4; i++) begin
            m = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
            v = ((m << 29) + n) / (n << 1);
            if (v > 16384) v = 16384;
            q[i] = (q[i] < 0) ? -int'(v) : int'(v);
          end
        end
        r = pose_rsp(p, q, STAT_INTERP);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Check results, then predict the item that transfers at this edge.
  always @(posedge clk_i) begin
    pti_out_t want;
    pti_out_t pred;
    bit typed;
    bit moved;
    if (rst_ni) begin
      moved = done_o || (start_i && !busy_o);
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (done_o) begin
        if (pose_q.size() == 0) begin
          $error("result with no expectation pending");
          failed = 1;
        end else begin
          want = pose_q.pop_front();
          if (rsp_o.out_x !== want.out_x) begin
            $error("out_x exp %h act %h", want.out_x, rsp_o.out_x); failed = 1;
          end
          if (rsp_o.out_y !== want.out_y) begin
            $error("out_y exp %h act %h", want.out_y, rsp_o.out_y); failed = 1;
          end
          if (rsp_o.out_z !== want.out_z) begin
            $error("out_z exp %h act %h", want.out_z, rsp_o.out_z); failed = 1;
          end
          if (rsp_o.out_qx !== want.out_qx) begin
            $error("out_qx exp %h act %h", want.out_qx, rsp_o.out_qx); failed = 1;
          end
          if (rsp_o.out_qy !== want.out_qy) begin
            $error("out_qy exp %h act %h", want.out_qy, rsp_o.out_qy); failed = 1;
          end
          if (rsp_o.out_qz !== want.out_qz) begin
            $error("out_qz exp %h act %h", want.out_qz, rsp_o.out_qz); failed = 1;
          end
          if (rsp_o.out_qw !== want.out_qw) begin
            $error("out_qw exp %h act %h", want.out_qw, rsp_o.out_qw); failed = 1;
          end
          if (rsp_o.status !== want.status) begin
            $error("status exp %0d act %0d", want.status, rsp_o.status); failed = 1;
          end
        end
      end
      if (start_i && !busy_o) begin
        typed = typed_q.pop_front();
        want = typed_rsp_q.pop_front();
        if (predict_pose(req_i, pred)) pose_q.insert(pose_q.size(), typed ? want : pred);
      end
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive one item and hold it until it transfers.
  task automatic send_item(pti_in_t it, bit typed = 0, pti_out_t rsp = '0);
    int gap;
    typed_q.insert(typed_q.size(), typed);
    typed_rsp_q.insert(typed_rsp_q.size(), rsp);
    start_i <= 1'b1;
    req_i <= it;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic pti_in_t mk(logic [1:0] act, logic [31:0] t, int px = 0, int py = 0,
                                 int pz = 0, shortint qx = 0, shortint qy = 0,
                                 shortint qz = 0, shortint qw = 0);
    pti_in_t it;
    it.action = act; it.time_us = t;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
    return it;
  endfunction

  function automatic pti_out_t code_rsp(logic [2:0] st);
    pti_out_t r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic shortint rand_quat();
    if ($urandom_range(9) == 0) return shortint'($urandom);
    return shortint'($urandom_range(32768)) - 16384;
  endfunction

  function automatic pti_in_t rand_load(logic [31:0] t);
    return mk(ACT_LOAD, t, $urandom, $urandom, $urandom,
              rand_quat(), rand_quat(), rand_quat(), rand_quat());
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    pti_out_t first_rsp;
    logic [31:0] t_abs;
    logic [31:0] span;
    int n_load;
    int n_qry;
    int done_items;
    bit drained;

    gap_pct = 27;

    first_rsp = '0;
    first_rsp.out_x = 32'h7fff_ffff; first_rsp.out_y = 32'h7fff_ffff;
    first_rsp.out_z = 32'h7fff_ffff; first_rsp.out_qx = 16'sd16384;
    first_rsp.status = STAT_FIRST;

    rows = '{
      '{mk(ACT_QUERY, 0), 1, code_rsp(STAT_EMPTY)},
      '{mk(ACT_LOAD, 1000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16384),
        1, code_rsp(STAT_LOADED)},
      '{mk(ACT_LOAD, 3000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           -16384, 16384, -16384, 16384), 1, code_rsp(STAT_LOADED)},
      '{mk(ACT_LOAD, 500, 12345, -54321, 7, 0, 0, 16384, 0), 1, code_rsp(STAT_LOADED)},
      '{mk(ACT_LOAD, 2500, -1, 1, 0, 100, -100, 50, -50), 1, code_rsp(STAT_LOADED)},
      '{mk(ACT_QUERY, 0), 1, first_rsp},
      '{mk(ACT_QUERY, 1000), 0, '0},
      '{mk(ACT_QUERY, 2000), 0, '0},
      '{mk(ACT_QUERY, 32'hffff_ffff), 0, '0},
      '{mk(ActUnused, 32'hffff_ffff, -1, -1, -1, -1, -1, -1, -1), 0, '0},
      '{mk(ACT_CLEAR, 0), 1, code_rsp(STAT_CLEARED)},
      '{mk(ACT_LOAD, 32'hffff_ffff, 0, 0, 0, -32768, -32768, 32767, -32768),
        1, code_rsp(STAT_LOADED)},
      '{mk(ACT_LOAD, 99, 0, 0, 0), 1, code_rsp(STAT_LOADED)},
      '{mk(ACT_LOAD, 299, 1 << 16, 0, 0), 1, code_rsp(STAT_LOADED)},
      '{mk(ACT_LOAD, 299, 5 << 16, 0, 0, 0, 0, 0, 16384), 1, code_rsp(STAT_LOADED)},
      '{mk(ACT_QUERY, 50), 0, '0},
      '{mk(ACT_QUERY, 200), 0, '0},
      '{mk(ACT_QUERY, 300), 0, '0},
      '{mk(ACT_QUERY, 1), 0, '0},
      '{mk(ACT_CLEAR, 0), 1, code_rsp(STAT_CLEARED)}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.req, row.typed, row.rsp);
    end

    // Random load/query sequences; sender idling changes with the phase.
    done_items = 0;
    drained = 1'b0;
    while (done_items < 200) begin
      gap_pct = (done_items < 100) ? 27 : 52;
      if (!drained && done_items >= 150) begin
        // hold off until every pending result is back
        drained = 1'b1;
        start_i <= 1'b0;
        @(negedge clk_i);
        wait (pose_q.size() == 0);
        @(posedge clk_i);
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: send_item(mk(ActUnused, $urandom, $urandom, $urandom, $urandom));
          1: send_item(mk(ACT_QUERY, $urandom));
          default: send_item(rand_load($urandom));
        endcase
        done_items++;
        continue;
      end
      send_item(mk(ACT_CLEAR, $urandom));
      t_abs = $urandom;
      span = 0;
      n_load = $urandom_range(1, 12);
      for (int k = 0; k < n_load; k++) begin
        send_item(rand_load(t_abs));
        case ($urandom_range(9))
          0: t_abs = t_abs - $urandom_range(1, 500);
          1: ;
          default: begin
            span += 5000;
            t_abs = t_abs + $urandom_range(1, 5000);
          end
        endcase
      end
      n_qry = $urandom_range(1, 8);
      repeat (n_qry) send_item(mk(ACT_QUERY, $urandom_range(0, span + 100)));
      done_items += n_load + n_qry + 1;
    end

    // Fill the table to the end and push past it.
    gap_pct = 0;
    send_item(mk(ACT_CLEAR, 0));
    t_abs = $urandom;
    for (int k = 0; k < Depth + 3; k++) begin
      send_item(rand_load(t_abs));
      t_abs = t_abs + $urandom_range(0, 20);
    end
    repeat (6) send_item(mk(ACT_QUERY, $urandom_range(0, Depth * 10)));
    send_item(mk(ACT_CLEAR, 0));

    start_i <= 1'b0;
    @(negedge clk_i);
    wait (pose_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
